### rtl/dirty_rect_tracker_macros.svh
// ----------------------------------------------------------------------------
// Dirty rectangle tracker assertion macros
// Concurrent property wrappers; compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECT_TRACKER_MACROS_SVH
`define DIRTY_RECT_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

`define DRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dirty_rect_tracker: same-cycle property failed");

`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dirty_rect_tracker: next-cycle property failed");

`else

`define DRT_ASSERT_SAME(label, clk, rst, ante, cons)

`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/drt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle tracker package
// Shared widths, operation and register codes, and record types.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int COORD_W   = 14;
   localparam int IN_W      = 16;
   localparam int IDX_W     = 5;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_NOTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 14'd640;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 14'd480;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IN_W-2:0]  x0;
      logic [IN_W-2:0]  y0;
      logic [IN_W:0]    x1;
      logic [IN_W:0]    y1;
      logic             size_ok;
      logic [IDX_W-1:0] idx;
   } drt_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } drt_entry_type;

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } drt_box_type;

   typedef struct packed {
      logic          keep;
      drt_entry_type rect;
      drt_box_type   box;
   } drt_geom_type;

endpackage

### rtl/drt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle tracker channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface drt_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic signed [15:0] rect_x;
   logic signed [15:0] rect_y;
   logic signed [15:0] rect_w;
   logic signed [15:0] rect_h;
   logic [4:0]        entry_index;

   modport source (output valid, op, rect_x, rect_y, rect_w, rect_h, entry_index,
                   input ready);
   modport sink (input valid, op, rect_x, rect_y, rect_w, rect_h, entry_index,
                 output ready);
endinterface

interface drt_rsp_if;
   logic        valid;
   logic        ready;
   logic        dirty_any;
   logic [13:0] union_x;
   logic [13:0] union_y;
   logic [13:0] union_w;
   logic [13:0] union_h;
   logic [5:0]  rect_count;
   logic        overflowed;
   logic        entry_valid;
   logic [13:0] entry_x;
   logic [13:0] entry_y;
   logic [13:0] entry_w;
   logic [13:0] entry_h;

   modport source (output valid, dirty_any, union_x, union_y, union_w, union_h,
                   rect_count, overflowed, entry_valid, entry_x, entry_y,
                   entry_w, entry_h,
                   input ready);
   modport sink (input valid, dirty_any, union_x, union_y, union_w, union_h,
                 rect_count, overflowed, entry_valid, entry_x, entry_y,
                 entry_w, entry_h,
                 output ready);
endinterface

### rtl/dirty_rect_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle tracker
// Keeps a damage bounding box and a bounded list of clipped rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per item: note a rectangle, clear all
//   tracking, or read a stored list entry. rsp_if returns exactly one
//   transaction per item with the box, the list count, the overflow flag and,
//   for a read, the stored entry.
//   csr_* writes tracking enable and screen size; write only while idle.
// Timing:
//   An accepted item is registered with its edge sums; the execute state then
//   clips, merges, and accesses the single-port-write list memory, and
//   registers the response valid. A new item is taken only in the idle state,
//   once the execute state for the previous item is done.
// Reset:
//   Synchronous; clears the box, count and overflow flag and restores the
//   registers. List memory is not cleared; only entries below the count read.
// Stall:
//   A waiting response holds; the next item is still taken but its update
//   waits in the execute state until the response is taken.
// ----------------------------------------------------------------------------
`include "dirty_rect_tracker_macros.svh"

module dirty_rect_tracker
   import drt_pkg::*;
#(
   parameter int RECT_CAPACITY = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   drt_req_if.sink              req_if,
   drt_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(RECT_CAPACITY + 1);
   localparam int AW = (RECT_CAPACITY > 1) ? $clog2(RECT_CAPACITY) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic               state_ff,     state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               enable_ff,    enable_in;
   logic [COORD_W-1:0] scr_w_ff,     scr_w_in;
   logic [COORD_W-1:0] scr_h_ff,     scr_h_in;
   drt_box_type        box_ff,       box_in;
   logic [CW-1:0]      count_ff,     count_in;
   logic               ovf_ff,       ovf_in;
   logic               ent_valid_ff, ent_valid_in;
   drt_item_type       item_ff,      item_in;
   drt_entry_type      rd_data_ff;

   drt_entry_type      mem [RECT_CAPACITY];
   logic               wr_en;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [AW+4:0]      idx_wide;
   logic [CW+5:0]      count_wide;
   logic               accept;
   logic               done;
   logic               idx_hit;
   drt_geom_type       geom;

   drt_geom u_geom (
      .item       (item_ff),
      .enabled    (enable_ff),
      .width_lim  (scr_w_ff),
      .height_lim (scr_h_ff),
      .box        (box_ff),
      .geom       (geom)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign done         = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_if.ready);
   assign idx_wide     = (AW + 5)'(item_ff.idx);
   assign rd_addr      = idx_wide[AW-1:0];
   assign idx_hit      = (CW + 5)'(item_ff.idx) < (CW + 5)'(count_ff);
   assign count_wide   = (CW + 6)'(count_ff);

   always_comb begin
      item_in.op      = req_if.op;
      item_in.x0      = req_if.rect_x[IN_W-1] ? '0 : req_if.rect_x[IN_W-2:0];
      item_in.y0      = req_if.rect_y[IN_W-1] ? '0 : req_if.rect_y[IN_W-2:0];
      item_in.x1      = 17'($signed({req_if.rect_x[IN_W-1], req_if.rect_x})
                          + $signed({req_if.rect_w[IN_W-1], req_if.rect_w}));
      item_in.y1      = 17'($signed({req_if.rect_y[IN_W-1], req_if.rect_y})
                          + $signed({req_if.rect_h[IN_W-1], req_if.rect_h}));
      item_in.size_ok = !req_if.rect_w[IN_W-1] && (req_if.rect_w != '0)
                        && !req_if.rect_h[IN_W-1] && (req_if.rect_h != '0);
      item_in.idx     = req_if.entry_index;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      enable_in    = enable_ff;
      scr_w_in     = scr_w_ff;
      scr_h_in     = scr_h_ff;
      box_in       = box_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      ent_valid_in = ent_valid_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_WIDTH:  scr_w_in  = csr_wdata;
            CSR_HEIGHT: scr_h_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               ent_valid_in = 1'b0;
               case (item_ff.op)
                  OP_NOTE: begin
                     if (geom.keep) begin
                        box_in = geom.box;
                        if (!ovf_ff) begin
                           if (count_ff < CW'(RECT_CAPACITY)) begin
                              wr_en    = 1'b1;
                              count_in = count_ff + CW'(1);
                           end else begin
                              ovf_in   = 1'b1;
                              count_in = '0;
                           end
                        end
                     end
                  end
                  OP_CLEAR: begin
                     box_in   = '0;
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_READ: begin
                     rd_en        = 1'b1;
                     ent_valid_in = idx_hit;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         scr_w_ff     <= WIDTH_RESET;
         scr_h_ff     <= HEIGHT_RESET;
         box_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ent_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
         scr_w_ff     <= scr_w_in;
         scr_h_ff     <= scr_h_in;
         box_ff       <= box_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ent_valid_ff <= ent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= geom.rect;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.dirty_any   = box_ff.valid;
   assign rsp_if.union_x     = box_ff.left;
   assign rsp_if.union_y     = box_ff.top;
   assign rsp_if.union_w     = box_ff.width;
   assign rsp_if.union_h     = box_ff.height;
   assign rsp_if.rect_count  = count_wide[5:0];
   assign rsp_if.overflowed  = ovf_ff;
   assign rsp_if.entry_valid = ent_valid_ff;
   assign rsp_if.entry_x     = ent_valid_ff ? rd_data_ff.x : '0;
   assign rsp_if.entry_y     = ent_valid_ff ? rd_data_ff.y : '0;
   assign rsp_if.entry_w     = ent_valid_ff ? rd_data_ff.w : '0;
   assign rsp_if.entry_h     = ent_valid_ff ? rd_data_ff.h : '0;

   `DRT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(RECT_CAPACITY))
   `DRT_ASSERT_SAME(a_ovf_empty, clock, reset, ovf_ff, count_ff == '0)
   `DRT_ASSERT_SAME(a_box_idle, clock, reset, !box_ff.valid, box_ff == '0)
   `DRT_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC && !req_if.ready)

endmodule

### rtl/drt_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle geometry
// Clips a registered note against the screen and merges it into the box.
// ----------------------------------------------------------------------------
module drt_geom
   import drt_pkg::*;
(
   input  drt_item_type       item,
   input  logic               enabled,
   input  logic [COORD_W-1:0] width_lim,
   input  logic [COORD_W-1:0] height_lim,
   input  drt_box_type        box,
   output drt_geom_type       geom
);

   logic signed [IN_W:0] x1_clip;
   logic signed [IN_W:0] y1_clip;
   logic [COORD_W-1:0]   l;
   logic [COORD_W-1:0]   t;
   logic [COORD_W-1:0]   r;
   logic [COORD_W-1:0]   b;
   logic [COORD_W:0]     box_r;
   logic [COORD_W:0]     box_b;
   logic [COORD_W:0]     new_r;
   logic [COORD_W:0]     new_b;
   logic [COORD_W-1:0]   new_l;
   logic [COORD_W-1:0]   new_t;
   logic [COORD_W:0]     span_w;
   logic [COORD_W:0]     span_h;

   always_comb begin
      x1_clip = $signed(item.x1);
      if ($signed(item.x1) > $signed({3'b000, width_lim})) begin
         x1_clip = $signed({3'b000, width_lim});
      end
      y1_clip = $signed(item.y1);
      if ($signed(item.y1) > $signed({3'b000, height_lim})) begin
         y1_clip = $signed({3'b000, height_lim});
      end

      l = item.x0[COORD_W-1:0];
      t = item.y0[COORD_W-1:0];
      r = x1_clip[COORD_W-1:0];
      b = y1_clip[COORD_W-1:0];

      geom.keep = enabled && item.size_ok
                  && ($signed({2'b00, item.x0}) < x1_clip)
                  && ($signed({2'b00, item.y0}) < y1_clip);
      geom.rect.x = l;
      geom.rect.y = t;
      geom.rect.w = r - l;
      geom.rect.h = b - t;

      box_r = {1'b0, box.left} + {1'b0, box.width};
      box_b = {1'b0, box.top} + {1'b0, box.height};
      new_l = (l < box.left) ? l : box.left;
      new_t = (t < box.top) ? t : box.top;
      new_r = ({1'b0, r} > box_r) ? {1'b0, r} : box_r;
      new_b = ({1'b0, b} > box_b) ? {1'b0, b} : box_b;
      span_w = new_r - {1'b0, new_l};
      span_h = new_b - {1'b0, new_t};

      geom.box.valid = 1'b1;
      if (box.valid) begin
         geom.box.left   = new_l;
         geom.box.top    = new_t;
         geom.box.width  = span_w[COORD_W-1:0];
         geom.box.height = span_h[COORD_W-1:0];
      end else begin
         geom.box.left   = l;
         geom.box.top    = t;
         geom.box.width  = r - l;
         geom.box.height = b - t;
      end
   end

endmodule
